// ===== design/utf8_line_edit_buffer_macros.svh =====
// Assertion macros used by the line edit buffer top level.
`ifndef UTF8_LINE_EDIT_BUFFER_MACROS_SVH
`define UTF8_LINE_EDIT_BUFFER_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define ULEB_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ULEB_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`else

`define ULEB_ASSERT(label, cond, msg)
`define ULEB_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// ===== design/uleb_pkg.sv =====
// Types and constants of the UTF-8 line edit buffer.
`default_nettype none

package uleb_pkg;

    // Default buffer size in bytes, terminator byte included
    localparam int ULEB_BUFFER_BYTES = 256;

    // Code point limits
    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO    = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] CP_LIMIT_1B   = 21'h000080;
    localparam logic [20:0] CP_LIMIT_2B   = 21'h000800;
    localparam logic [20:0] CP_LIMIT_3B   = 21'h010000;

    // Lead and continuation byte marks
    localparam logic [7:0] LEAD_2B   = 8'hC0;
    localparam logic [7:0] LEAD_3B   = 8'hE0;
    localparam logic [7:0] LEAD_4B   = 8'hF0;
    localparam logic [7:0] CONT_MARK = 8'h80;
    localparam logic [7:0] CONT_MASK = 8'h3F;

    // Request kinds
    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    // Encoded code point: byte 0 is the lead byte
    typedef struct packed {
        logic            valid;
        logic [2:0]      size;
        logic [3:0][7:0] bytes;
    } enc_t;

endpackage

`default_nettype wire

// ===== design/uleb_encoder.sv =====
// UTF-8 encoder: checks a code point and builds its 1 to 4 bytes.
`default_nettype none

module uleb_encoder (
    input  logic [20:0]   code_point,
    output uleb_pkg::enc_t enc
);
    import uleb_pkg::*;

    logic [7:0] cont_hi;
    logic [7:0] cont_mid;
    logic [7:0] cont_lo;

    // Continuation bytes for the three 6-bit groups
    assign cont_hi  = ({2'b00, code_point[17:12]} & CONT_MASK) | CONT_MARK;
    assign cont_mid = ({2'b00, code_point[11:6]}  & CONT_MASK) | CONT_MARK;
    assign cont_lo  = ({2'b00, code_point[5:0]}   & CONT_MASK) | CONT_MARK;

    // Refuse zero, surrogates and values past the Unicode range
    always_comb begin
        enc.valid = (code_point != '0) && (code_point <= CP_MAX) &&
                    !((code_point >= CP_SURR_LO) && (code_point <= CP_SURR_HI));
        enc.bytes = '0;
        if (code_point < CP_LIMIT_1B) begin
            enc.size     = 3'd1;
            enc.bytes[0] = code_point[7:0];
        end else if (code_point < CP_LIMIT_2B) begin
            enc.size     = 3'd2;
            enc.bytes[0] = {3'b000, code_point[10:6]} | LEAD_2B;
            enc.bytes[1] = cont_lo;
        end else if (code_point < CP_LIMIT_3B) begin
            enc.size     = 3'd3;
            enc.bytes[0] = {4'b0000, code_point[15:12]} | LEAD_3B;
            enc.bytes[1] = cont_mid;
            enc.bytes[2] = cont_lo;
        end else begin
            enc.size     = 3'd4;
            enc.bytes[0] = {5'b00000, code_point[20:18]} | LEAD_4B;
            enc.bytes[1] = cont_hi;
            enc.bytes[2] = cont_mid;
            enc.bytes[3] = cont_lo;
        end
    end

endmodule

`default_nettype wire

// ===== design/utf8_line_edit_buffer.sv =====
// Top level of the UTF-8 line edit buffer.
//
// Usage: each request on the s_ channel is one edit (append a code point,
// delete the last character, clear, or read one byte); the m_ channel
// returns exactly one result per request, in order.
// Requests are taken into an input register; the edit is applied as a request
// moves on from the input register into the result register, which drives
// m_tvalid and m_tdata.
// Throughput is one request per cycle while m_tready is high: the text is
// held in four byte banks (position mod 4) so an append writes all its
// bytes together, and a small stack of character lengths, with its top two
// entries in registers, gives the size of the last character to delete at once.
// A read fetches its byte when the request is accepted; a byte written by
// the request just ahead of it is forwarded.
// When the receiver holds m_tready low, the result register and then the
// input register fill, and s_tready drops until the result is taken.
// Reset (aresetn low at a clock edge) empties the buffer and drops any
// pending request and result; the text memory itself is not cleared.
`default_nettype none
`include "utf8_line_edit_buffer_macros.svh"

module utf8_line_edit_buffer #(
    parameter int BUFFER_BYTES = uleb_pkg::ULEB_BUFFER_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [20:0] code_point, [28:21] read_index, [31:29] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] accepted, [3:1] bytes_added, [11:4] read_byte,
                                   // [19:12] byte_length, [27:20] char_count, [31:28] zero
);
    import uleb_pkg::*;

    localparam int POS_W = $clog2(BUFFER_BYTES);
    localparam int ROW_W = POS_W - 2;
    localparam int ROWS  = (BUFFER_BYTES + 3) / 4;
    localparam int CMP_W = (POS_W > 8) ? POS_W : 8;
    localparam logic [POS_W:0] BUF_LIM = (POS_W + 1)'(BUFFER_BYTES);

    // Input stage
    logic                 in_valid_reg;
    action_t              action_reg;
    logic [20:0]          cp_reg;
    logic [7:0]           idx_reg;
    logic [3:0][7:0]      rd_data_reg;

    // Buffer state
    logic [POS_W-1:0]     used_bytes_reg, used_bytes_next;
    logic [POS_W-1:0]     used_chars_reg, used_chars_next;
    logic [2:0]           last_len_reg;
    logic [2:0]           prev_len_reg;
    logic [2:0]           len_mem [BUFFER_BYTES];

    // Output stage
    logic                 m_valid_reg;
    logic [31:0]          m_data_reg, m_data_next;

    logic                 advance;
    logic                 s_accept;
    logic                 process;
    logic                 do_append;
    logic                 do_delete;
    logic                 append_ok;
    logic                 delete_ok;
    logic                 bytes_in_range;
    logic                 last_len_ok;
    enc_t                 enc;
    logic [CMP_W-1:0]     s_idx_ext;
    logic [ROW_W-1:0]     rd_row;
    logic [CMP_W-1:0]     idx_ext;
    logic [CMP_W-1:0]     used_ext;
    logic [CMP_W-1:0]     chars_ext;
    logic [3:0]           wr_en;
    logic [3:0][ROW_W-1:0] wr_row;
    logic [3:0][7:0]      wr_byte;
    logic                 res_accepted;
    logic [2:0]           res_added;
    logic [7:0]           res_byte;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign process  = in_valid_reg && advance;

    // Read address comes straight from the request
    assign s_idx_ext = CMP_W'(s_tdata[28:21]);
    assign rd_row    = s_idx_ext[POS_W-1:2];

    // Hold the request in the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            action_reg <= action_t'(s_tuser);
            cp_reg     <= s_tdata[20:0];
            idx_reg    <= s_tdata[28:21];
        end
    end

    uleb_encoder u_encoder (
        .code_point (cp_reg),
        .enc        (enc)
    );

    // Decide which edit takes effect
    assign append_ok = enc.valid &&
                       (({1'b0, used_bytes_reg} + (POS_W + 1)'(enc.size)) < BUF_LIM);
    assign delete_ok = (used_bytes_reg != '0);
    assign do_append = process && (action_reg == ACT_APPEND) && append_ok;
    assign do_delete = process && (action_reg == ACT_DELETE) && delete_ok;

    // Route each encoded byte to the bank of its position
    always_comb begin
        logic [1:0]       k;
        logic [POS_W-1:0] pos;
        for (int j = 0; j < 4; j++) begin
            k          = 2'(j) - used_bytes_reg[1:0];
            pos        = used_bytes_reg + POS_W'(k);
            wr_en[j]   = do_append && ({1'b0, k} < enc.size);
            wr_row[j]  = pos[POS_W-1:2];
            wr_byte[j] = enc.bytes[k];
        end
    end

    // Text banks: write on append, read at request accept, forward same-row write
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0] text_mem [ROWS];

        always_ff @(posedge aclk) begin
            if (wr_en[b]) begin
                text_mem[wr_row[b]] <= wr_byte[b];
            end
            if (s_accept) begin
                if (wr_en[b] && (wr_row[b] == rd_row)) begin
                    rd_data_reg[b] <= wr_byte[b];
                end else begin
                    rd_data_reg[b] <= text_mem[rd_row];
                end
            end
        end
    end

    // Character length stack: push on append, pop on delete
    always_ff @(posedge aclk) begin
        if (do_append) begin
            len_mem[used_chars_reg] <= enc.size;
            last_len_reg            <= enc.size;
            prev_len_reg            <= last_len_reg;
        end else if (do_delete) begin
            last_len_reg <= prev_len_reg;
            prev_len_reg <= len_mem[used_chars_reg - POS_W'(3)];
        end
    end

    // Next counters
    always_comb begin
        used_bytes_next = used_bytes_reg;
        used_chars_next = used_chars_reg;
        if (process) begin
            case (action_reg)
                ACT_APPEND: begin
                    if (append_ok) begin
                        used_bytes_next = used_bytes_reg + POS_W'(enc.size);
                        used_chars_next = used_chars_reg + POS_W'(1);
                    end
                end
                ACT_DELETE: begin
                    if (delete_ok) begin
                        used_bytes_next = used_bytes_reg - POS_W'(last_len_reg);
                        if (used_chars_reg != '0) begin
                            used_chars_next = used_chars_reg - POS_W'(1);
                        end
                    end
                end
                ACT_CLEAR: begin
                    used_bytes_next = '0;
                    used_chars_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_bytes_reg <= '0;
            used_chars_reg <= '0;
        end else begin
            used_bytes_reg <= used_bytes_next;
            used_chars_reg <= used_chars_next;
        end
    end

    // Build the result from the state after the edit
    assign idx_ext   = CMP_W'(idx_reg);
    assign used_ext  = CMP_W'(used_bytes_next);
    assign chars_ext = CMP_W'(used_chars_next);

    always_comb begin
        res_accepted = 1'b1;
        res_added    = 3'd0;
        res_byte     = 8'd0;
        case (action_reg)
            ACT_APPEND: begin
                res_accepted = append_ok;
                res_added    = append_ok ? enc.size : 3'd0;
            end
            ACT_DELETE: begin
                res_accepted = delete_ok;
            end
            ACT_READ: begin
                if (idx_ext < CMP_W'(used_bytes_reg)) begin
                    res_byte = rd_data_reg[idx_reg[1:0]];
                end
            end
            default: begin
            end
        endcase
        m_data_next = {4'b0000, chars_ext[7:0], used_ext[7:0], res_byte,
                       res_added, res_accepted};
    end

    // Result register: load when empty or taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign bytes_in_range = ({1'b0, used_bytes_reg} < BUF_LIM);
    assign last_len_ok    = (used_chars_reg == '0) ||
                            ((last_len_reg != 3'd0) && (last_len_reg <= 3'd4));

    `ULEB_ASSERT(a_chars_le_bytes, used_chars_reg <= used_bytes_reg, "more chars than bytes")
    `ULEB_ASSERT(a_bytes_in_range, bytes_in_range, "byte length beyond buffer")
    `ULEB_ASSERT(a_last_len_ok, last_len_ok, "bad last char length")
    `ULEB_ASSERT_NEXT(a_result_follows, process, m_valid_reg, "processed request left no result")

endmodule

`default_nettype wire
